### rtl/assert_macros.svh
// Assertion macros shared by the congestion window pushback RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define CWRP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that implies another in the same cycle.
`define CWRP_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// A condition that implies another in the following cycle.
`define CWRP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/cwrp_pkg.sv
// Types and constants shared by the congestion window pushback modules.
package cwrp_pkg;

  // Sequencer states: idle, compare, divide by five, update and multiply, result.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_DIV,
    ST_MUL,
    ST_DONE
  } cwrp_state_t;

  // How the scale factor moves for the current word.
  typedef enum logic [2:0] {
    BR_HOLD,
    BR_DROP_HARD,
    BR_DROP_SOFT,
    BR_RESET,
    BR_GROW
  } cwrp_branch_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic capture;
    logic cmp_en;
    logic div_en;
    logic mul_en;
    logic load;
  } cwrp_cmd_t;

  // Configuration register indexes (bit 2 of the byte address).
  localparam logic REG_PACING_ENABLE = 1'b0;
  localparam logic REG_FLOOR_RATE    = 1'b1;

  localparam int unsigned PADDR_W = 3;

  localparam logic [31:0] FLOOR_RATE_RESET = 32'd30000;

  // ceil(2^32 / 5); exact floor division by five for operands below 2^30.
  localparam logic [31:0] RECIP5       = 32'd858993460;
  localparam int unsigned RECIP5_SHIFT = 32;

  // Round-up term for the growth step, ceil(x / 20) = floor((x + 19) / 20).
  localparam int unsigned GROW_ROUND = 19;

endpackage

### rtl/cwrp_ctrl.sv
// Sequencer for the congestion window pushback block.
module cwrp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  output logic               grant_valid,
  input  logic               grant_stall,
  output cwrp_pkg::cwrp_cmd_t cmd
);
  import cwrp_pkg::*;

  cwrp_state_t state, state_next;
  logic        grant_valid_next;
  logic        load;
  logic        accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      grant_valid <= 1'b0;
    end else begin
      state       <= state_next;
      grant_valid <= grant_valid_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) state_next = ST_CMP;
      end
      ST_CMP:  state_next = ST_DIV;
      ST_DIV:  state_next = ST_MUL;
      ST_MUL:  state_next = ST_DONE;
      ST_DONE: begin
        if (load) state_next = req_valid ? ST_CMP : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    load        = (state == ST_DONE) && (!grant_valid || !grant_stall);
    req_stall   = !((state == ST_IDLE) || load);
    accept      = req_valid && !req_stall;
    cmd.capture = accept;
    cmd.cmp_en  = (state == ST_CMP);
    cmd.div_en  = (state == ST_DIV);
    cmd.mul_en  = (state == ST_MUL);
    cmd.load    = load;
    if (load) begin
      grant_valid_next = 1'b1;
    end else begin
      grant_valid_next = grant_valid && grant_stall;
    end
  end

`include "assert_macros.svh"

  `CWRP_ASSERT_NEXT(a_accept_starts_cmp, accept, state == ST_CMP, "accepted word did not start")
  `CWRP_ASSERT_IMPLIES(a_grant_from_done, $rose(grant_valid), $past(state) == ST_DONE, "result without finish")
  `CWRP_ASSERT_IMPLIES(a_load_slot_free, load, !grant_valid || !grant_stall, "result overwritten")

endmodule

### rtl/cwrp_dp.sv
// Datapath for the congestion window pushback block: compares, scale update, rate product.
module cwrp_dp #(
  parameter int unsigned SCALE_FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  cwrp_pkg::cwrp_cmd_t cmd,
  input  logic                pacing_enable,
  input  logic [31:0]         floor_rate,
  input  logic [31:0]         requested_rate,
  input  logic [31:0]         window_bytes,
  input  logic [31:0]         unacked_bytes,
  input  logic [31:0]         queued_bytes,
  output logic [31:0]         granted_rate
);
  import cwrp_pkg::*;

  localparam int unsigned SW = SCALE_FRAC_BITS + 1;
  // scale * 21 + 19 fits in SW + 5 bits.
  localparam int unsigned YW = SW + 5;
  localparam logic [SW-1:0] SCALE_ONE = {1'b1, {SCALE_FRAC_BITS{1'b0}}};

  // Captured word.
  logic [31:0] req_q, win_q, unacked_q, queued_q;

  // State and intermediate registers.
  logic [SW-1:0]    scale;
  logic [SW-1:0]    scale_next;
  cwrp_branch_t     branch_q, branch_sel;
  logic [YW-1:0]    y_q, y_sel;
  logic [YW-1:0]    q_q;
  logic [31+SW:0]   prod_q;

  // Compare stage signals.
  logic [32:0]      inflight;
  logic [33:0]      twice_inflight, thrice_win;
  logic [35:0]      ten_inflight;
  logic [YW-1:0]    s_ext, s9, s19, s21r;

  logic [YW+31:0]   recip_prod;
  logic [31:0]      adj;
  logic [31:0]      result;

  always_comb begin
    inflight       = {1'b0, unacked_q} + (pacing_enable ? {1'b0, queued_q} : 33'd0);
    twice_inflight = {inflight, 1'b0};
    thrice_win     = {1'b0, win_q, 1'b0} + {2'b00, win_q};
    ten_inflight   = ({3'b000, inflight} << 3) + ({3'b000, inflight} << 1);

    s_ext = {{(YW - SW){1'b0}}, scale};
    s9    = (s_ext << 3) + s_ext;
    s19   = (s_ext << 4) + (s_ext << 1) + s_ext;
    s21r  = (s_ext << 4) + (s_ext << 2) + s_ext + YW'(GROW_ROUND);

    // The divide by ten or twenty becomes a shift and a divide by five.
    if (win_q == 32'd0) begin
      branch_sel = BR_HOLD;
      y_sel      = '0;
    end else if (twice_inflight > thrice_win) begin
      branch_sel = BR_DROP_HARD;
      y_sel      = s9 >> 1;
    end else if (inflight > {1'b0, win_q}) begin
      branch_sel = BR_DROP_SOFT;
      y_sel      = s19 >> 2;
    end else if (ten_inflight < {4'b0000, win_q}) begin
      branch_sel = BR_RESET;
      y_sel      = '0;
    end else begin
      branch_sel = BR_GROW;
      y_sel      = s21r >> 2;
    end
  end

  assign recip_prod = (YW + 32)'(y_q) * (YW + 32)'(RECIP5);

  always_comb begin
    case (branch_q)
      BR_HOLD:      scale_next = scale;
      BR_DROP_HARD,
      BR_DROP_SOFT: scale_next = (q_q == '0) ? SW'(1) : q_q[SW-1:0];
      BR_RESET:     scale_next = SCALE_ONE;
      BR_GROW:      scale_next = (q_q > YW'(SCALE_ONE)) ? SCALE_ONE : q_q[SW-1:0];
      default:      scale_next = scale;
    endcase
  end

  always_comb begin
    adj = prod_q[SCALE_FRAC_BITS +: 32];
    if (branch_q == BR_HOLD) begin
      result = req_q;
    end else if (adj < floor_rate) begin
      result = (req_q < floor_rate) ? req_q : floor_rate;
    end else begin
      result = adj;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= SCALE_ONE;
    end else if (cmd.mul_en) begin
      scale <= scale_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q     <= requested_rate;
      win_q     <= window_bytes;
      unacked_q <= unacked_bytes;
      queued_q  <= queued_bytes;
    end
    if (cmd.cmp_en) begin
      branch_q <= branch_sel;
      y_q      <= y_sel;
    end
    if (cmd.div_en) begin
      q_q <= recip_prod[YW+31:RECIP5_SHIFT];
    end
    if (cmd.mul_en) begin
      prod_q <= (32 + SW)'(req_q) * (32 + SW)'(scale_next);
    end
    if (cmd.load) begin
      granted_rate <= result;
    end
  end

`include "assert_macros.svh"

  `CWRP_ASSERT_ALWAYS(a_scale_range, (scale != '0) && (scale <= SCALE_ONE), "scale out of range")
  `CWRP_ASSERT_NEXT(a_zero_window_holds, cmd.mul_en && (branch_q == BR_HOLD), $stable(scale), "scale moved on zero window")

endmodule

### rtl/congestion_window_rate_pushback.sv
// Top level of the congestion window rate pushback block with its register port.
//
// This block scales a requested bitrate down when the bytes in flight overfill the
// congestion window and lets it recover when they do not. Each input word carries
// the requested rate, the window, the unacknowledged bytes and the pacer queue depth;
// each one yields exactly one result word with the granted rate. A kept scale factor
// with SCALE_FRAC_BITS fraction bits (1.0 after reset) is multiplied by 0.9 when the
// fill exceeds 1.5, by 0.95 above 1.0, reset to 1.0 below 0.1, and grown by 1.05
// (rounded up, capped at 1.0) otherwise; the thresholds are exact cross-multiplied
// compares. The grant is the request times the new scale, held at or above floor_rate
// unless the request itself is lower. A zero window passes the request through and
// leaves the scale alone. From acceptance, a word passes through a compare step, a
// divide by five done as a reciprocal multiply, a step that updates the scale and
// forms the rate product, and a step that applies the floor and loads the output
// register, which waits while the output is stalled. The next word is taken in the
// same cycle a result is loaded; one word at a time is in flight because each word's
// scale update feeds the next word.
// Registers sit on an APB-style port: pacing_enable at byte address 0, floor_rate at 4.
module congestion_window_rate_pushback #(
  parameter int unsigned SCALE_FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  // Input word channel.
  input  logic                         req_valid,
  output logic                         req_stall,
  input  logic [31:0]                  requested_rate,
  input  logic [31:0]                  window_bytes,
  input  logic [31:0]                  unacked_bytes,
  input  logic [31:0]                  queued_bytes,
  // Result word channel.
  output logic                         grant_valid,
  input  logic                         grant_stall,
  output logic [31:0]                  granted_rate,
  // Register port.
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cwrp_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import cwrp_pkg::*;

  logic        pacing_enable;
  logic [31:0] floor_rate;
  logic        reg_write;
  cwrp_cmd_t   cmd;

  // The port never inserts wait states.
  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite && pready;

  // Registers are decoded on bit 2 of the byte address; the low two bits are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      pacing_enable <= 1'b0;
      floor_rate    <= FLOOR_RATE_RESET;
    end else if (reg_write) begin
      case (paddr[2])
        REG_PACING_ENABLE: pacing_enable <= pwdata[0];
        REG_FLOOR_RATE:    floor_rate    <= pwdata;
        default:           floor_rate    <= floor_rate;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_PACING_ENABLE: prdata = {31'd0, pacing_enable};
      REG_FLOOR_RATE:    prdata = floor_rate;
      default:           prdata = 32'd0;
    endcase
  end

  // The sequencer steps each word through the datapath and owns the output valid.
  cwrp_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .grant_valid (grant_valid),
    .grant_stall (grant_stall),
    .cmd         (cmd)
  );

  cwrp_dp #(
    .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .pacing_enable  (pacing_enable),
    .floor_rate     (floor_rate),
    .requested_rate (requested_rate),
    .window_bytes   (window_bytes),
    .unacked_bytes  (unacked_bytes),
    .queued_bytes   (queued_bytes),
    .granted_rate   (granted_rate)
  );

endmodule

### tb/testbench.sv
// Self-checking testbench for the congestion window rate pushback block.
`timescale 1ns / 1ps

module testbench;
  import cwrp_pkg::*;

  // Fraction bits of the scale factor; matches the block's default parameter.
  localparam int unsigned FRAC = 16;
  localparam logic [63:0] SCALE_ONE = 64'd1 << FRAC;
  localparam logic [63:0] MAX32 = 64'hFFFF_FFFF;
  // Cycles with no handshake on any channel before the run is declared hung.
  // The longest legitimate quiet stretch is the receiver hold-off below.
  localparam int unsigned HANG_LIMIT = 5000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned WORDS_PER_PHASE = 215;

  // Ranges of fill (in flight over window) that the random episodes aim for.
  typedef enum int {
    FILL_HARD,
    FILL_SOFT,
    FILL_LOW,
    FILL_MID,
    FILL_EDGE,
    FILL_BYPASS,
    FILL_NOISE
  } fill_kind_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  logic [31:0] requested_rate = '0;
  logic [31:0] window_bytes = '0;
  logic [31:0] unacked_bytes = '0;
  logic [31:0] queued_bytes = '0;
  logic grant_valid;
  logic grant_stall = 1'b0;
  logic [31:0] granted_rate;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  congestion_window_rate_pushback dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .requested_rate(requested_rate),
    .window_bytes(window_bytes),
    .unacked_bytes(unacked_bytes),
    .queued_bytes(queued_bytes),
    .grant_valid(grant_valid),
    .grant_stall(grant_stall),
    .granted_rate(granted_rate),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirror of the block's configuration and its kept scale factor.
  logic pacing_q = 1'b0;
  logic [31:0] floor_q = FLOOR_RATE_RESET;
  logic [FRAC:0] scale_q = SCALE_ONE[FRAC:0];

  // Granted rates still owed by the block, oldest first.
  logic [31:0] grant_q[$];

  // Idling controls shared by the sender, the receiver and the tests.
  bit tx_gaps = 1'b1;
  bit rx_random = 1'b1;
  int unsigned hold_req = 0;

  int unsigned faults = 0;
  int unsigned words_sent = 0;
  int unsigned grants_checked = 0;
  int unsigned settings_used = 1;
  int unsigned n_hard = 0, n_soft = 0, n_reset = 0, n_grow = 0;
  int unsigned n_bypass = 0, n_floored = 0, n_min_scale = 0;
  int unsigned quiet_cycles = 0;

  task automatic report_fault(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    faults++;
  endtask

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) pick_gap = 0;
    else if (r < 88) pick_gap = $urandom_range(1, 3);
    else if (r < 97) pick_gap = $urandom_range(4, 12);
    else pick_gap = $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] rand64();
    rand64 = {$urandom, $urandom};
  endfunction

  // Works out the grant for one word and moves the mirrored scale factor the
  // way the block is meant to. All compares are exact, done in 64 bits.
  task automatic predict_grant(input logic [31:0] req, input logic [31:0] win,
                               input logic [31:0] unacked, input logic [31:0] queued,
                               output logic [31:0] grant);
    logic [63:0] inflight, s64, nxt, adj;
    s64 = 64'(scale_q);
    if (win == 0) begin
      // A zero window means pushback is off: pass through, keep the scale.
      grant = req;
      n_bypass++;
    end else begin
      inflight = 64'(unacked) + (pacing_q ? 64'(queued) : 64'd0);
      if (2 * inflight > 3 * 64'(win)) begin
        nxt = (s64 * 9) / 10;
        if (nxt == 0) nxt = 1;
        n_hard++;
      end else if (inflight > 64'(win)) begin
        nxt = (s64 * 19) / 20;
        if (nxt == 0) nxt = 1;
        n_soft++;
      end else if (10 * inflight < 64'(win)) begin
        nxt = SCALE_ONE;
        n_reset++;
      end else begin
        // Growth rounds up so that a scale of one LSB can recover.
        nxt = (s64 * 21 + GROW_ROUND) / 20;
        if (nxt > SCALE_ONE) nxt = SCALE_ONE;
        n_grow++;
      end
      if (nxt == 1) n_min_scale++;
      scale_q = nxt[FRAC:0];
      adj = (64'(req) * nxt) >> FRAC;
      if (adj < 64'(floor_q)) begin
        adj = (req < floor_q) ? 64'(req) : 64'(floor_q);
        n_floored++;
      end
      grant = adj[31:0];
    end
  endtask

  // Offers one word. Entered and left just after a falling edge. A gap lowers
  // valid in this step and raises it at a later one, so valid is never
  // assigned twice in one step.
  task automatic send_word(input logic [31:0] req, input logic [31:0] win,
                           input logic [31:0] unacked, input logic [31:0] queued);
    int unsigned gap;
    logic [31:0] grant;
    gap = tx_gaps ? pick_gap() : 0;
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    requested_rate <= req;
    window_bytes <= win;
    unacked_bytes <= unacked;
    queued_bytes <= queued;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    predict_grant(req, win, unacked, queued, grant);
    grant_q.push_back(grant);
    words_sent++;
    @(negedge clk);
  endtask

  // Lowers valid and waits until every owed grant has come out. Since every
  // word yields a grant, an empty queue means the block is idle.
  task automatic wait_drained();
    req_valid <= 1'b0;
    while (grant_q.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // One register write: setup cycle, then access cycle until pready. The bus
  // then rests idle so that a following write starts cleanly.
  task automatic write_reg(input logic idx, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_PACING_ENABLE) pacing_q = data[0];
    else floor_q = data;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(input logic [31:0] pacing_word, input logic [31:0] floor_word);
    wait_drained();
    write_reg(REG_PACING_ENABLE, pacing_word);
    write_reg(REG_FLOOR_RATE, floor_word);
    settings_used++;
  endtask

  // Splits a wanted in-flight count over the unacked and queued fields. With
  // pacing off the queue field carries random bytes that must be ignored.
  task automatic send_fill(input logic [31:0] req, input logic [31:0] win,
                           input logic [63:0] target);
    logic [63:0] ua, qd;
    if (target > 2 * MAX32) target = 2 * MAX32;
    if (pacing_q) begin
      qd = rand64() % (target + 1);
      if (qd > MAX32) qd = MAX32;
      ua = target - qd;
      if (ua > MAX32) begin
        ua = MAX32;
        qd = target - MAX32;
      end
    end else begin
      ua = (target > MAX32) ? MAX32 : target;
      qd = 64'($urandom);
    end
    send_word(req, win, ua[31:0], qd[31:0]);
  endtask

  function automatic logic [31:0] rand_window();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 3) rand_window = $urandom;
    else if (r < 6) rand_window = $urandom_range(1, 65535);
    else if (r < 9) rand_window = $urandom_range(1, 1 << 24);
    else rand_window = $urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF;
    if (rand_window == 0) rand_window = 1;
  endfunction

  function automatic logic [31:0] rand_request();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) rand_request = $urandom;
    else if (r < 8) rand_request = $urandom_range(0, 100000);
    else if (r < 9) rand_request = $urandom_range(0, 1) ? 32'd0 : 32'hFFFF_FFFF;
    else rand_request = $urandom_range(0, 1) ? floor_q : floor_q - 1;
  endfunction

  // In-flight count for a window that lands in the chosen fill range.
  function automatic logic [63:0] fill_for(input fill_kind_t kind, input logic [63:0] w);
    case (kind)
      FILL_HARD: fill_for = (3 * w) / 2 + 1 + rand64() % (w + 1);
      FILL_SOFT: fill_for = w + 1 + rand64() % (w / 2 + 1);
      FILL_LOW:  fill_for = rand64() % (w / 10 + 1);
      FILL_MID:  fill_for = w / 10 + rand64() % (w - w / 10 + 1);
      default: begin
        // Right at or next to one of the three thresholds.
        case ($urandom_range(0, 5))
          0: fill_for = w;
          1: fill_for = w + 1;
          2: fill_for = (3 * w) / 2;
          3: fill_for = (3 * w) / 2 + 1;
          4: fill_for = w / 10;
          default: fill_for = (w + 9) / 10;
        endcase
      end
    endcase
  endfunction

  // Extremes of every field, each way the scale can move, the exact
  // threshold ties, the floor in both forms and the zero window.
  task automatic test_directed();
    send_word(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(32'd0, 32'd0, 32'd0, 32'd0);
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0);
    send_word(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'd0);
    send_word(32'd5000000, 32'd1000, 32'd1500, 32'd0);
    send_word(32'd5000000, 32'd1000, 32'd1501, 32'd0);
    send_word(32'd5000000, 32'd1000, 32'd1000, 32'd0);
    send_word(32'd5000000, 32'd1000, 32'd1001, 32'd0);
    send_word(32'd5000000, 32'd1000, 32'd100, 32'd0);
    send_word(32'd5000000, 32'd1000, 32'd99, 32'd0);
    send_word(32'd20000, 32'd1000, 32'd1200, 32'd0);
    send_word(32'd31000, 32'd1000, 32'd1200, 32'd0);
    send_word(32'd0, 32'd1000, 32'd3000, 32'd0);
    send_word(32'd123456, 32'd10, 32'd0, 32'hFFFF_FFFF);
    // Upper bits set with bit 0 low, then high: only bit 0 may count.
    set_config(32'hFFFF_FFFE, FLOOR_RATE_RESET);
    send_word(32'd777777, 32'd10, 32'd50, 32'd0);
    set_config(32'hFFFF_FFFF, FLOOR_RATE_RESET);
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(32'd9000000, 32'd100, 32'd50, 32'd60);
    send_word(32'd9000000, 32'd100, 32'd0, 32'd9);
    send_word(32'd9000000, 32'd100, 32'd0, 32'd10);
  endtask

  // Drives the scale all the way down to one LSB with hard drops, then lets
  // it climb back through the round-up growth step.
  task automatic test_decay_recovery();
    int i;
    set_config(32'd0, 32'd0);
    for (i = 0; i < 115; i++)
      send_word(32'hFFFF_FFFF - i, 32'd1000, 32'd2000, $urandom);
    for (i = 0; i < 25; i++)
      send_word(32'hFFFF_FFFF, 32'd1000, 32'd1000, $urandom);
    for (i = 0; i < 10; i++)
      send_word($urandom, 32'd1000, 32'd1100, $urandom);
  endtask

  // The receiver holds off for a long stretch while words keep coming back to
  // back, so the block fills and has to stall its input.
  task automatic test_backpressure();
    int i;
    tx_gaps = 1'b0;
    hold_req = HOLD_CYCLES;
    for (i = 0; i < 16; i++)
      send_fill(rand_request(), rand_window(), 64'd0);
    tx_gaps = 1'b1;
  endtask

  // Several register settings, each with one of four idling patterns. Most words
  // come in runs that stay in one fill range so the scale travels far; the
  // rest are bypasses and fully random words.
  task automatic test_random_phases();
    int phase, left, run, k;
    fill_kind_t kind;
    logic [31:0] win;
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: set_config(32'd0, FLOOR_RATE_RESET);
        1: set_config(32'd1, 32'd0);
        2: set_config(32'd1, 32'hFFFF_FFFF);
        3: set_config($urandom & 32'hFFFF_FFFE, $urandom);
        4: set_config($urandom | 32'd1, $urandom_range(0, 1000000));
        5: set_config(32'd0, 32'd0);
        6: set_config(32'd1, FLOOR_RATE_RESET);
        default: set_config($urandom, $urandom_range(0, 100000000));
      endcase
      tx_gaps = (phase % 4 == 0) || (phase % 4 == 2);
      rx_random = (phase % 4 == 0) || (phase % 4 == 3);
      left = WORDS_PER_PHASE;
      while (left > 0) begin
        k = $urandom_range(0, 99);
        if (k < 22) kind = FILL_HARD;
        else if (k < 42) kind = FILL_SOFT;
        else if (k < 54) kind = FILL_LOW;
        else if (k < 74) kind = FILL_MID;
        else if (k < 85) kind = FILL_EDGE;
        else if (k < 90) kind = FILL_BYPASS;
        else kind = FILL_NOISE;
        run = $urandom_range(1, 12);
        if (run > left) run = left;
        left -= run;
        repeat (run) begin
          if (kind == FILL_NOISE) begin
            send_word($urandom, $urandom, $urandom, $urandom);
          end else if (kind == FILL_BYPASS) begin
            send_word(rand_request(), 32'd0, $urandom, $urandom);
          end else begin
            win = rand_window();
            send_fill(rand_request(), win, fill_for(kind, 64'(win)));
          end
        end
      end
    end
    tx_gaps = 1'b1;
    rx_random = 1'b1;
  endtask

  // The receiver decides its stall once per falling edge: a pending long
  // hold-off wins, then any random stall run, else it takes the word.
  initial begin : result_receiver
    int unsigned hold_left, stall_left;
    hold_left = 0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left == 0 && stall_left == 0 && rx_random && $urandom_range(0, 1) == 0)
        stall_left = pick_gap();
      if (hold_left != 0) begin
        hold_left--;
        grant_stall <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        grant_stall <= 1'b1;
      end else begin
        grant_stall <= 1'b0;
      end
    end
  end

  // Every accepted result word is compared against the oldest owed grant.
  always @(posedge clk) begin : grant_checker
    logic [31:0] owed;
    if (!rst && grant_valid && !grant_stall) begin
      if (grant_q.size() == 0) begin
        report_fault($sformatf("grant %0d with no word outstanding", granted_rate));
      end else begin
        owed = grant_q.pop_front();
        grants_checked++;
        if (granted_rate !== owed)
          report_fault($sformatf("granted_rate %0d, expected %0d", granted_rate, owed));
      end
    end
  end

  // Ends a hung run: any handshake or register access restarts the count.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (grant_valid && !grant_stall) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("timeout: no handshake for %0d cycles, %0d grants owed",
               quiet_cycles, grant_q.size());
      $display("testbench NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_decay_recovery();
    test_backpressure();
    test_random_phases();
    wait_drained();
    // Runs on after draining, to catch stray result words.
    repeat (12) @(posedge clk);
    $display("covered %0d words, %0d grants checked, %0d register settings",
             words_sent, grants_checked, settings_used);
    $display("scale moves: %0d hard, %0d soft, %0d reset, %0d grow; ",
             n_hard, n_soft, n_reset, n_grow,
             "%0d bypass, %0d floored, %0d at one LSB",
             n_bypass, n_floored, n_min_scale);
    if (faults == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/cwrp_pkg.sv
rtl/cwrp_ctrl.sv
rtl/cwrp_dp.sv
rtl/congestion_window_rate_pushback.sv
tb/testbench.sv
